[rtl/sqch_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqch_pkg
// Shared types, codes and constants for the square channel with sweep.
// ----------------------------------------------------------------------------
package sqch_pkg;

  // Function codes carried on the request channel
  localparam logic [2:0] FUNC_TRIGGER  = 3'd0;
  localparam logic [2:0] FUNC_PERIOD   = 3'd1;
  localparam logic [2:0] FUNC_DUTY     = 3'd2;
  localparam logic [2:0] FUNC_ENVELOPE = 3'd3;
  localparam logic [2:0] FUNC_LENGTH   = 3'd4;
  localparam logic [2:0] FUNC_SWEEP    = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_WAVE_DUTY   = 2'd0;
  localparam logic [1:0] CFG_SWEEP_PACE  = 2'd1;
  localparam logic [1:0] CFG_SWEEP_SHIFT = 2'd2;
  localparam logic [1:0] CFG_SWEEP_DOWN  = 2'd3;

  localparam int          CFG_DATA_W  = 3;
  localparam logic [10:0] PERIOD_MAX  = 11'h7FF;
  localparam logic [3:0]  VOLUME_MAX  = 4'hF;
  localparam logic [6:0]  LENGTH_FULL = 7'd64;

  // Duty patterns, bit i is the waveform level at step i
  localparam logic [1:0] DUTY_12 = 2'd0;
  localparam logic [1:0] DUTY_25 = 2'd1;
  localparam logic [1:0] DUTY_50 = 2'd2;
  localparam logic [1:0] DUTY_75 = 2'd3;

  typedef enum logic [2:0] {
    OP_TRIGGER,
    OP_PERIOD,
    OP_DUTY,
    OP_ENVELOPE,
    OP_LENGTH,
    OP_SWEEP,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [10:0] period;
    logic [3:0]  initial_volume;
    logic        envelope_up;
    logic [2:0]  envelope_pace;
    logic        length_enable;
    logic [5:0]  initial_length;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  sample;
    logic        active;
    logic [10:0] period_now;
  } out_item_t;

  // Decoded command passed from the front end to the channel core
  typedef struct packed {
    op_t         op;
    logic [10:0] period;
    logic [3:0]  initial_volume;
    logic        envelope_up;
    logic [2:0]  envelope_pace;
    logic        length_enable;
    logic [5:0]  initial_length;
  } cmd_t;

  typedef struct packed {
    logic [1:0] wave_duty;
    logic [2:0] sweep_pace;
    logic [2:0] sweep_shift;
    logic       sweep_down;
  } cfg_t;

  function automatic logic duty_bit(input logic [1:0] wave, input logic [2:0] step);
    logic [7:0] pattern;
    unique case (wave)
      DUTY_12: pattern = 8'h80;
      DUTY_25: pattern = 8'h81;
      DUTY_50: pattern = 8'hE1;
      DUTY_75: pattern = 8'h7E;
      default: pattern = 8'h80;
    endcase
    return pattern[step];
  endfunction

endpackage

[rtl/square_channel_with_sweep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_channel_with_sweep
// Pulse channel with period sweep, volume envelope and length timer.
// ----------------------------------------------------------------------------
// Every request (trigger, period write or one tick of the duty, envelope,
// length or sweep clock) yields exactly one result carrying the sample, the
// active flag and the current period. The block sustains one request per
// clock while the result side keeps up; a request passes the decode register
// and command queue, and its result leaves the channel core's output
// register. The queue of QUEUE_DEPTH commands lets the request side keep
// running while the result side stalls. Configuration registers are written
// through cfg_we/cfg_index/cfg_data and take effect for requests executed
// afterwards; write them only while no request is in flight.
module square_channel_with_sweep #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sqch_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sqch_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [sqch_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sqch_pkg::*;

  cfg_t cfg;
  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic core_valid, core_ready;
  cmd_t core_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WAVE_DUTY:   cfg.wave_duty   <= cfg_data[1:0];
        CFG_SWEEP_PACE:  cfg.sweep_pace  <= cfg_data[2:0];
        CFG_SWEEP_SHIFT: cfg.sweep_shift <= cfg_data[2:0];
        CFG_SWEEP_DOWN:  cfg.sweep_down  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  sqch_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  sqch_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (core_valid),
    .pop_ready  (core_ready),
    .pop_cmd    (core_cmd)
  );

  sqch_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (core_valid),
    .cmd_ready (core_ready),
    .cmd       (core_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A silenced channel never produces a nonzero sample
  a_silent_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.active |-> out_data.sample == 4'd0)
    else $error("nonzero sample while channel is silenced");

  // Request side only backs up when the decode stage holds a command
  a_front_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> front_valid && !front_ready)
    else $error("request stalled with free decode stage");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !front_valid && !core_valid)
    else $error("pipeline not empty after reset");

endmodule

[rtl/sqch_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqch_front
// Accepts requests, decodes the function code and holds one decoded command
// until the queue takes it.
// ----------------------------------------------------------------------------
module sqch_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sqch_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output sqch_pkg::cmd_t    cmd
);
  import sqch_pkg::*;

  logic cmd_valid_next;
  cmd_t cmd_dec;

  // Free slot when empty or when the held command leaves this cycle
  assign in_ready = !cmd_valid || cmd_ready;

  // Function code to operation
  always_comb begin
    cmd_dec.period         = in_data.period;
    cmd_dec.initial_volume = in_data.initial_volume;
    cmd_dec.envelope_up    = in_data.envelope_up;
    cmd_dec.envelope_pace  = in_data.envelope_pace;
    cmd_dec.length_enable  = in_data.length_enable;
    cmd_dec.initial_length = in_data.initial_length;
    unique case (in_data.func)
      FUNC_TRIGGER:  cmd_dec.op = OP_TRIGGER;
      FUNC_PERIOD:   cmd_dec.op = OP_PERIOD;
      FUNC_DUTY:     cmd_dec.op = OP_DUTY;
      FUNC_ENVELOPE: cmd_dec.op = OP_ENVELOPE;
      FUNC_LENGTH:   cmd_dec.op = OP_LENGTH;
      FUNC_SWEEP:    cmd_dec.op = OP_SWEEP;
      default:       cmd_dec.op = OP_NONE;
    endcase
  end

  always_comb begin
    cmd_valid_next = cmd_valid;
    if (in_valid && in_ready) begin
      cmd_valid_next = 1'b1;
    end else if (cmd_ready) begin
      cmd_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= cmd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= cmd_dec;
    end
  end

endmodule

[rtl/sqch_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqch_queue
// Small register queue of decoded commands between front end and core.
// ----------------------------------------------------------------------------
module sqch_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  sqch_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sqch_pkg::cmd_t pop_cmd
);
  import sqch_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic             push, pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
    end
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/sqch_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqch_core
// Channel state: duty sequencer, envelope, length timer and period sweep.
// Executes one command per cycle, unless the result stage is held, into a registered result stage.
// ----------------------------------------------------------------------------
module sqch_core (
  input  logic               clk,
  input  logic               rst,
  input  sqch_pkg::cfg_t     cfg,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  sqch_pkg::cmd_t     cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output sqch_pkg::out_item_t out_data
);
  import sqch_pkg::*;

  logic [10:0] period_reg, period_reg_next;
  logic [10:0] period_count, period_count_next;
  logic [2:0]  duty_step, duty_step_next;
  logic [3:0]  volume, volume_next;
  logic        env_dir_latched, env_dir_latched_next;
  logic [2:0]  env_pace_latched, env_pace_latched_next;
  logic [2:0]  env_count, env_count_next;
  logic        env_running, env_running_next;
  logic [6:0]  length_count, length_count_next;
  logic        length_running, length_running_next;
  logic        length_expired, length_expired_next;
  logic        overflowed, overflowed_next;
  logic [2:0]  sweep_count, sweep_count_next;
  logic        out_valid_next;
  out_item_t   result;

  logic        silenced, silenced_next, exec;
  logic [10:0] period_inc;
  logic [11:0] duty_sum;
  logic [2:0]  env_inc, sweep_inc, sweep_pace_eff;
  logic [6:0]  length_dec;
  logic [10:0] delta;
  logic [11:0] sweep_sum;
  logic [10:0] sweep_target;
  logic        sweep_ovf;

  assign silenced  = length_expired || overflowed;
  assign cmd_ready = !out_valid || out_ready;
  assign exec      = cmd_valid && cmd_ready;

  // Per-unit arithmetic
  assign period_inc     = period_count + 11'd1;
  assign duty_sum       = {1'b0, period_inc} + {1'b0, period_reg};
  assign env_inc        = env_count + 3'd1;
  assign sweep_inc      = sweep_count + 3'd1;
  assign sweep_pace_eff = (cfg.sweep_pace == 3'd0) ? 3'd1 : cfg.sweep_pace;
  assign length_dec     = (length_count != 7'd0) ? length_count - 7'd1 : 7'd0;
  assign delta          = period_reg >> cfg.sweep_shift;
  assign sweep_sum      = {1'b0, period_reg} + {1'b0, delta};
  assign sweep_ovf      = sweep_sum[11];

  always_comb begin
    if (cfg.sweep_down) begin
      sweep_target = (period_reg > delta) ? period_reg - delta : 11'd0;
    end else if (sweep_ovf) begin
      sweep_target = period_reg;
    end else begin
      sweep_target = sweep_sum[10:0];
    end
  end

  // Next channel state for the command being executed
  always_comb begin
    period_reg_next       = period_reg;
    period_count_next     = period_count;
    duty_step_next        = duty_step;
    volume_next           = volume;
    env_dir_latched_next  = env_dir_latched;
    env_pace_latched_next = env_pace_latched;
    env_count_next        = env_count;
    env_running_next      = env_running;
    length_count_next     = length_count;
    length_running_next   = length_running;
    length_expired_next   = length_expired;
    overflowed_next       = overflowed;
    sweep_count_next      = sweep_count;
    if (exec) begin
      unique case (cmd.op)
        OP_TRIGGER: begin
          period_reg_next       = cmd.period;
          volume_next           = cmd.initial_volume;
          env_dir_latched_next  = cmd.envelope_up;
          env_pace_latched_next = cmd.envelope_pace;
          env_running_next      = cmd.envelope_pace != 3'd0;
          env_count_next        = 3'd0;
          duty_step_next        = 3'd0;
          period_count_next     = 11'd0;
          length_expired_next   = 1'b0;
          overflowed_next       = 1'b0;
          length_running_next   = cmd.length_enable;
          length_count_next     = LENGTH_FULL - {1'b0, cmd.initial_length};
          sweep_count_next      = 3'd0;
        end
        OP_PERIOD: begin
          period_reg_next = cmd.period;
        end
        OP_DUTY: begin
          if (!silenced) begin
            // wrap once count + period reaches the period limit
            if (period_inc == 11'd0 || duty_sum[11]) begin
              period_count_next = 11'd0;
              duty_step_next    = duty_step + 3'd1;
            end else begin
              period_count_next = period_inc;
            end
          end
        end
        OP_ENVELOPE: begin
          if (!silenced && env_running) begin
            if (env_inc < env_pace_latched) begin
              env_count_next = env_inc;
            end else begin
              env_count_next = 3'd0;
              if (env_dir_latched && volume < VOLUME_MAX) begin
                volume_next = volume + 4'd1;
              end else if (!env_dir_latched && volume != 4'd0) begin
                volume_next = volume - 4'd1;
              end else begin
                env_running_next = 1'b0;
              end
            end
          end
        end
        OP_LENGTH: begin
          if (length_running && !length_expired) begin
            length_count_next = length_dec;
            if (length_dec == 7'd0) begin
              length_expired_next = 1'b1;
              length_running_next = 1'b0;
            end
          end
        end
        OP_SWEEP: begin
          if (!silenced) begin
            if (sweep_inc < sweep_pace_eff) begin
              sweep_count_next = sweep_inc;
            end else begin
              sweep_count_next = 3'd0;
              if (!cfg.sweep_down && sweep_ovf) begin
                overflowed_next = 1'b1;
              end
              if (cfg.sweep_pace != 3'd0) begin
                period_reg_next = sweep_target;
              end
            end
          end
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Result from the updated state
  assign silenced_next = length_expired_next || overflowed_next;
  always_comb begin
    result.active     = !silenced_next;
    result.period_now = period_reg_next;
    if (!silenced_next && duty_bit(cfg.wave_duty, duty_step_next)) begin
      result.sample = volume_next;
    end else begin
      result.sample = 4'd0;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (exec) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_reg       <= '0;
      period_count     <= '0;
      duty_step        <= '0;
      volume           <= '0;
      env_dir_latched  <= 1'b0;
      env_pace_latched <= '0;
      env_count        <= '0;
      env_running      <= 1'b0;
      length_count     <= '0;
      length_running   <= 1'b0;
      length_expired   <= 1'b0;
      overflowed       <= 1'b0;
      sweep_count      <= '0;
      out_valid        <= 1'b0;
    end else begin
      period_reg       <= period_reg_next;
      period_count     <= period_count_next;
      duty_step        <= duty_step_next;
      volume           <= volume_next;
      env_dir_latched  <= env_dir_latched_next;
      env_pace_latched <= env_pace_latched_next;
      env_count        <= env_count_next;
      env_running      <= env_running_next;
      length_count     <= length_count_next;
      length_running   <= length_running_next;
      length_expired   <= length_expired_next;
      overflowed       <= overflowed_next;
      sweep_count      <= sweep_count_next;
      out_valid        <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_data <= result;
    end
  end

endmodule

[tb/square_channel_with_sweep_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_channel_with_sweep_tb
// Self-checking bench for the pulse channel with sweep, envelope and length.
// ----------------------------------------------------------------------------
// A queue-fed driver offers requests in random bursts while the receiver
// stalls on its own pattern, with one long hold-off that backs up the block.
// A cycle-free channel model predicts each result as its request is taken,
// and the monitor compares every result, field by field, in order. Register
// settings change only between phases, once the block has drained.
module square_channel_with_sweep_tb;
  import sqch_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 8;
  localparam int PERIOD_LIMIT     = 2048;
  localparam int DRAIN_CYCLES     = 8;
  localparam int HOLD_CYCLES      = 300;
  localparam int RANDOM_PHASES    = 9;
  localparam int EVENTS_PER_PHASE = 150;
  localparam int HOLD_PHASE       = 4;
  localparam int MAX_REPORTS      = 40;
  localparam int TIMEOUT_NS       = 3_000_000;

  // Codes the block must ignore
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

  // Waveform per duty setting, bit i is the level at step i
  localparam logic [3:0][7:0] DUTY_WAVES = {8'h7E, 8'hE1, 8'h81, 8'h80};

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [1:0]            cfg_index = CFG_WAVE_DUTY;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  square_channel_with_sweep i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stimulus and expectations
  in_item_t  pending_events[$];
  out_item_t expected_samples[$];

  int   error_count    = 0;
  int   checked_count  = 0;
  int   settings_used  = 0;
  int   func_seen [8]  = '{default: 0};
  logic req_taken      = 1'b0;

  // Sender and receiver pacing
  int   gap_left     = 0;
  int   burst_left   = 0;
  logic sender_gaps  = 1'b1;
  int   holds_asked  = 0;
  int   holds_seen   = 0;
  int   hold_left    = 0;
  int   pattern_left = 0;
  int   stall_pct    = 0;

  // Channel model state
  cfg_t        model_cfg       = '0;
  logic [10:0] ch_period       = '0;
  logic [10:0] ch_period_count = '0;
  logic [2:0]  ch_duty_step    = '0;
  logic [3:0]  ch_volume       = '0;
  logic        ch_env_up       = 1'b0;
  logic [2:0]  ch_env_pace     = '0;
  logic [2:0]  ch_env_count    = '0;
  logic        ch_env_run      = 1'b0;
  logic [6:0]  ch_len_count    = '0;
  logic        ch_len_run      = 1'b0;
  logic        ch_len_done     = 1'b0;
  logic        ch_ovf          = 1'b0;
  logic [2:0]  ch_sweep_count  = '0;

  // Apply one request to the channel model and form its result
  task automatic advance_channel(input in_item_t ev, output out_item_t res);
    logic [10:0] delta;
    logic [11:0] raised;
    logic [10:0] next_period;
    int          pace;
    logic        muted;
    logic        level;
    muted = ch_len_done || ch_ovf;
    case (ev.func)
      FUNC_TRIGGER: begin
        ch_period       = ev.period;
        ch_volume       = ev.initial_volume;
        ch_env_up       = ev.envelope_up;
        ch_env_pace     = ev.envelope_pace;
        ch_env_run      = ev.envelope_pace != 3'd0;
        ch_env_count    = '0;
        ch_duty_step    = '0;
        ch_period_count = '0;
        ch_len_done     = 1'b0;
        ch_ovf          = 1'b0;
        ch_len_run      = ev.length_enable;
        ch_len_count    = LENGTH_FULL - {1'b0, ev.initial_length};
        ch_sweep_count  = '0;
      end
      FUNC_PERIOD: begin
        ch_period = ev.period;
      end
      FUNC_DUTY: begin
        // count wraps at 2048; step once the count reaches the limit
        if (!muted) begin
          ch_period_count = ch_period_count + 11'd1;
          if (ch_period_count == '0 ||
              int'(ch_period_count) >= PERIOD_LIMIT - int'(ch_period)) begin
            ch_period_count = '0;
            ch_duty_step    = ch_duty_step + 3'd1;
          end
        end
      end
      FUNC_ENVELOPE: begin
        if (!muted && ch_env_run) begin
          ch_env_count = ch_env_count + 3'd1;
          if (ch_env_count >= ch_env_pace) begin
            ch_env_count = '0;
            if (ch_env_up && ch_volume < VOLUME_MAX) begin
              ch_volume = ch_volume + 4'd1;
            end else if (!ch_env_up && ch_volume > 4'd0) begin
              ch_volume = ch_volume - 4'd1;
            end else begin
              ch_env_run = 1'b0;
            end
          end
        end
      end
      FUNC_LENGTH: begin
        // keeps counting through a sweep overflow
        if (ch_len_run && !ch_len_done) begin
          if (ch_len_count > 7'd0) ch_len_count = ch_len_count - 7'd1;
          if (ch_len_count == 7'd0) begin
            ch_len_done = 1'b1;
            ch_len_run  = 1'b0;
          end
        end
      end
      FUNC_SWEEP: begin
        if (!muted) begin
          pace = (model_cfg.sweep_pace == 3'd0) ? 1 : int'(model_cfg.sweep_pace);
          ch_sweep_count = ch_sweep_count + 3'd1;
          if (int'(ch_sweep_count) >= pace) begin
            ch_sweep_count = '0;
            delta = ch_period >> model_cfg.sweep_shift;
            if (model_cfg.sweep_down) begin
              next_period = (ch_period > delta) ? ch_period - delta : '0;
            end else begin
              raised = {1'b0, ch_period} + {1'b0, delta};
              if (raised > {1'b0, PERIOD_MAX}) begin
                ch_ovf      = 1'b1;
                next_period = ch_period;
              end else begin
                next_period = raised[10:0];
              end
            end
            // pace 0 flags overflow but leaves the period alone
            if (model_cfg.sweep_pace != 3'd0) ch_period = next_period;
          end
        end
      end
      default: ;
    endcase
    muted = ch_len_done || ch_ovf;
    level = DUTY_WAVES[model_cfg.wave_duty][ch_duty_step];
    res.sample     = (muted || !level) ? 4'd0 : ch_volume;
    res.active     = !muted;
    res.period_now = ch_period;
  endtask

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Monitor: check results in order, then predict newly taken requests
  always @(posedge clk) begin : monitor
    out_item_t predicted;
    out_item_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: sample %0d active %0d period %0d",
                                    out_data.sample, out_data.active, out_data.period_now));
        end else begin
          want = expected_samples.pop_front();
          checked_count++;
          if (out_data.sample !== want.sample)
            report_mismatch($sformatf("result %0d sample %0d, want %0d",
                                      checked_count, out_data.sample, want.sample));
          if (out_data.active !== want.active)
            report_mismatch($sformatf("result %0d active %0d, want %0d",
                                      checked_count, out_data.active, want.active));
          if (out_data.period_now !== want.period_now)
            report_mismatch($sformatf("result %0d period %0d, want %0d",
                                      checked_count, out_data.period_now, want.period_now));
        end
      end
      if (in_valid && in_ready) begin
        advance_channel(in_data, predicted);
        expected_samples.push_back(predicted);
        func_seen[in_data.func]++;
      end
    end
  end

  // Driver: bursts of requests from the queue, with random gaps between in phases that allow them
  always @(negedge clk) begin : sender
    if (!rst && (!in_valid || req_taken)) begin
      if (gap_left > 0 || pending_events.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_data  <= pending_events.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(24, 1);
          gap_left   = sender_gaps ? $urandom_range(8, 0) : 0;
        end
      end
    end
  end

  // Receiver: stall rate redrawn at random for each pattern; long hold on request
  always @(negedge clk) begin : receiver
    if (holds_seen != holds_asked) begin
      holds_seen = holds_asked;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(256, 32);
        case ($urandom_range(3, 0))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      pattern_left--;
      out_ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  function automatic in_item_t make_event(input logic [2:0] func, input logic [10:0] period,
                                          input logic [3:0] volume, input logic up,
                                          input logic [2:0] pace, input logic len_en,
                                          input logic [5:0] len);
    in_item_t ev;
    ev.func           = func;
    ev.period         = period;
    ev.initial_volume = volume;
    ev.envelope_up    = up;
    ev.envelope_pace  = pace;
    ev.length_enable  = len_en;
    ev.initial_length = len;
    return ev;
  endfunction

  // Mostly ticks with random content; periods and lengths lean toward the top
  function automatic in_item_t random_event();
    in_item_t    ev;
    int          pick;
    logic [31:0] raw;
    raw  = $urandom;
    ev   = raw[$bits(in_item_t)-1:0];
    pick = $urandom_range(99, 0);
    if (pick < 8)       ev.func = FUNC_TRIGGER;
    else if (pick < 14) ev.func = FUNC_PERIOD;
    else if (pick < 44) ev.func = FUNC_DUTY;
    else if (pick < 60) ev.func = FUNC_ENVELOPE;
    else if (pick < 76) ev.func = FUNC_LENGTH;
    else if (pick < 95) ev.func = FUNC_SWEEP;
    else                ev.func = pick[0] ? FUNC_SPARE_6 : FUNC_SPARE_7;
    if ($urandom_range(1, 0) == 1) ev.period = PERIOD_MAX - 11'($urandom_range(12, 0));
    if ($urandom_range(1, 0) == 1) ev.initial_length = 6'd63 - 6'($urandom_range(8, 0));
    return ev;
  endfunction

  task automatic wait_idle();
    while (pending_events.size() != 0 || in_valid || expected_samples.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_WAVE_DUTY:   model_cfg.wave_duty   = value[1:0];
      CFG_SWEEP_PACE:  model_cfg.sweep_pace  = value;
      CFG_SWEEP_SHIFT: model_cfg.sweep_shift = value;
      CFG_SWEEP_DOWN:  model_cfg.sweep_down  = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drain the block, then load a full register setting
  task automatic apply_setting(input logic [1:0] wave, input logic [2:0] pace,
                               input logic [2:0] shift, input logic down);
    wait_idle();
    write_reg(CFG_WAVE_DUTY, {1'b0, wave});
    write_reg(CFG_SWEEP_PACE, pace);
    write_reg(CFG_SWEEP_SHIFT, shift);
    write_reg(CFG_SWEEP_DOWN, {2'b00, down});
    settings_used++;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int phase;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: sweep up by half, 75% duty
    apply_setting(DUTY_75, 3'd1, 3'd1, 1'b0);
    pending_events.push_back(make_event(FUNC_TRIGGER, PERIOD_MAX, 4'hF, 1'b0, 3'd1, 1'b1, 6'd63));
    pending_events.push_back(make_event(FUNC_DUTY, '0, '0, 1'b0, '0, 1'b0, '0));
    pending_events.push_back(make_event(FUNC_ENVELOPE, '0, '0, 1'b0, '0, 1'b0, '0));
    // single-tick length expiry, then ticks while silenced
    pending_events.push_back(make_event(FUNC_LENGTH, '0, '0, 1'b0, '0, 1'b0, '0));
    pending_events.push_back(make_event(FUNC_DUTY, '1, '1, 1'b1, '1, 1'b1, '1));
    pending_events.push_back(make_event(FUNC_ENVELOPE, '1, '1, 1'b1, '1, 1'b1, '1));
    pending_events.push_back(make_event(FUNC_SWEEP, '1, '1, 1'b1, '1, 1'b1, '1));
    pending_events.push_back(make_event(FUNC_LENGTH, '1, '1, 1'b1, '1, 1'b1, '1));
    pending_events.push_back(make_event(FUNC_SPARE_6, '1, '1, 1'b1, '1, 1'b1, '1));
    pending_events.push_back(make_event(FUNC_SPARE_7, '0, '0, 1'b0, '0, 1'b0, '0));
    // envelope pace 0 never runs; period raised mid-count steps at once
    pending_events.push_back(make_event(FUNC_TRIGGER, '0, '0, 1'b1, 3'd0, 1'b0, '0));
    pending_events.push_back(make_event(FUNC_ENVELOPE, '0, '0, 1'b0, '0, 1'b0, '0));
    repeat (3) pending_events.push_back(make_event(FUNC_DUTY, '0, '0, 1'b0, '0, 1'b0, '0));
    pending_events.push_back(make_event(FUNC_PERIOD, PERIOD_MAX, '0, 1'b0, '0, 1'b0, '0));
    pending_events.push_back(make_event(FUNC_DUTY, '0, '0, 1'b0, '0, 1'b0, '0));
    // overflow on sweep up, length still counts down afterwards
    pending_events.push_back(make_event(FUNC_TRIGGER, PERIOD_MAX, 4'd9, 1'b1, 3'd7, 1'b1, 6'd62));
    pending_events.push_back(make_event(FUNC_SWEEP, '0, '0, 1'b0, '0, 1'b0, '0));
    repeat (2) pending_events.push_back(make_event(FUNC_LENGTH, '0, '0, 1'b0, '0, 1'b0, '0));

    // Directed: slow sweep down, count left part way
    apply_setting(DUTY_12, 3'd7, 3'd0, 1'b1);
    pending_events.push_back(make_event(FUNC_TRIGGER, 11'd5, 4'hF, 1'b1, 3'd1, 1'b0, '0));
    repeat (3) pending_events.push_back(make_event(FUNC_SWEEP, '0, '0, 1'b0, '0, 1'b0, '0));

    // pace lowered below the count: acts on the next tick, period drops to zero
    apply_setting(DUTY_25, 3'd2, 3'd0, 1'b1);
    repeat (2) pending_events.push_back(make_event(FUNC_SWEEP, '0, '0, 1'b0, '0, 1'b0, '0));

    // pace 0: overflow flagged, period never written
    apply_setting(DUTY_50, 3'd0, 3'd7, 1'b0);
    pending_events.push_back(make_event(FUNC_TRIGGER, PERIOD_MAX, 4'd7, 1'b0, 3'd2, 1'b0, '0));
    pending_events.push_back(make_event(FUNC_SWEEP, '0, '0, 1'b0, '0, 1'b0, '0));
    pending_events.push_back(make_event(FUNC_TRIGGER, 11'd1024, 4'd7, 1'b0, 3'd2, 1'b0, '0));
    pending_events.push_back(make_event(FUNC_SWEEP, '0, '0, 1'b0, '0, 1'b0, '0));

    // Random phases, extremes first
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        apply_setting(DUTY_12, 3'd0, 3'd0, 1'b0);
      end else if (phase == 1) begin
        apply_setting(DUTY_75, 3'd7, 3'd7, 1'b1);
      end else begin
        apply_setting(2'($urandom_range(3, 0)), 3'($urandom_range(7, 0)),
                      3'($urandom_range(7, 0)), 1'($urandom_range(1, 0)));
      end
      sender_gaps = (phase % 3) != 0;
      if (phase == HOLD_PHASE) holds_asked++;
      repeat (EVENTS_PER_PHASE) pending_events.push_back(random_event());
    end

    wait_idle();
    $display("Covered %0d requests: %0d triggers, %0d period writes, %0d ticks, %0d spare codes",
             func_seen[0] + func_seen[1] + func_seen[2] + func_seen[3] + func_seen[4] +
             func_seen[5] + func_seen[6] + func_seen[7],
             func_seen[0], func_seen[1],
             func_seen[2] + func_seen[3] + func_seen[4] + func_seen[5],
             func_seen[6] + func_seen[7]);
    $display("Checked %0d results over %0d register settings, %0d mismatches",
             checked_count, settings_used, error_count);
    if (error_count == 0) begin
      $display("square_channel_with_sweep test passed");
    end else begin
      $display("square_channel_with_sweep test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout with %0d results outstanding", expected_samples.size());
    $display("square_channel_with_sweep test failed");
    $finish;
  end

endmodule
